@@ rtl/stack_machine_execute_core_defines.svh @@
// assertion macros shared by the stack machine checker
`ifndef STACK_MACHINE_EXECUTE_CORE_DEFINES_SVH
`define STACK_MACHINE_EXECUTE_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define SMX_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define SMX_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/smx_pkg.sv @@
// shared types, codes and constants of the stack machine execute core
package smx_pkg;

  localparam int unsigned MEM_WORDS_DEF = 4096;

  // opcodes
  localparam logic [6:0] OP_PUSH  = 7'd0;
  localparam logic [6:0] OP_IPUSH = 7'd1;
  localparam logic [6:0] OP_PUSHI = 7'd2;
  localparam logic [6:0] OP_POP   = 7'd3;
  localparam logic [6:0] OP_IPOP  = 7'd4;
  localparam logic [6:0] OP_DUP   = 7'd5;
  localparam logic [6:0] OP_ALU   = 7'd6;
  localparam logic [6:0] OP_JMP   = 7'd7;
  localparam logic [6:0] OP_JPZ   = 7'd8;
  localparam logic [6:0] OP_CALL  = 7'd9;
  localparam logic [6:0] OP_RET   = 7'd10;
  localparam logic [6:0] OP_RND   = 7'd11;
  localparam logic [6:0] OP_WRITE = 7'd12;
  localparam logic [6:0] OP_READ  = 7'd13;
  localparam logic [6:0] OP_HALT  = 7'd99;

  // alu sub-operations
  localparam logic [3:0] ALU_AND = 4'd0;
  localparam logic [3:0] ALU_OR  = 4'd1;
  localparam logic [3:0] ALU_XOR = 4'd2;
  localparam logic [3:0] ALU_NOT = 4'd3;
  localparam logic [3:0] ALU_NEG = 4'd4;
  localparam logic [3:0] ALU_ADD = 4'd5;
  localparam logic [3:0] ALU_SUB = 4'd6;
  localparam logic [3:0] ALU_MUL = 4'd7;
  localparam logic [3:0] ALU_DIV = 4'd8;
  localparam logic [3:0] ALU_MOD = 4'd9;
  localparam logic [3:0] ALU_EQ  = 4'd10;
  localparam logic [3:0] ALU_NE  = 4'd11;
  localparam logic [3:0] ALU_GT  = 4'd12;
  localparam logic [3:0] ALU_GE  = 4'd13;
  localparam logic [3:0] ALU_LT  = 4'd14;
  localparam logic [3:0] ALU_LE  = 4'd15;

  // error codes
  localparam logic [2:0] ERR_OK        = 3'd0;
  localparam logic [2:0] ERR_UNWRITTEN = 3'd1;
  localparam logic [2:0] ERR_ADDR      = 3'd2;
  localparam logic [2:0] ERR_UNDER     = 3'd3;
  localparam logic [2:0] ERR_OPCODE    = 3'd4;
  localparam logic [2:0] ERR_DIVZERO   = 3'd5;
  localparam logic [2:0] ERR_OVER      = 3'd6;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_DEC, ST_RA, ST_CA, ST_CHK, ST_RB, ST_CB,
    ST_EXEC, ST_DIVGO, ST_DIV, ST_WR, ST_FIN
  } smx_state_t;

  typedef struct packed {
    logic [6:0]         func;
    logic signed [31:0] argument;
    logic signed [31:0] read_value;
    logic [30:0]        random_value;
  } smx_in_t;

  typedef struct packed {
    logic [15:0]        next_pc;
    logic               write_valid;
    logic signed [31:0] write_value;
    logic               halted;
    logic [2:0]         error_code;
  } smx_out_t;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } smx_div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quotient;
    logic [31:0] remainder;
  } smx_div_rsp_t;

endpackage

@@ rtl/smx_ram.sv @@
// generic single write port ram with registered read
module smx_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/smx_div.sv @@
// iterative unsigned 32-bit divider, one quotient bit per cycle
module smx_div (
  input  logic                  clk,
  input  logic                  rst,
  input  smx_pkg::smx_div_req_t req,
  output smx_pkg::smx_div_rsp_t rsp
);

  logic        busy;
  logic        done;
  logic [4:0]  cnt;
  logic [31:0] quo;
  logic [31:0] rem;
  logic [31:0] dvs;
  logic [33:0] diff;

  // trial subtract of the shifted partial remainder
  assign diff = {1'b0, rem, quo[31]} - {2'b00, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        quo  <= req.dividend;
        rem  <= '0;
        dvs  <= req.divisor;
      end else if (busy) begin
        if (!diff[33]) begin
          rem <= diff[31:0];
          quo <= {quo[30:0], 1'b1};
        end else begin
          rem <= {rem[30:0], quo[31]};
          quo <= {quo[30:0], 1'b0};
        end
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule

@@ rtl/stack_machine_execute_core.sv @@
// stack machine execute core: sequencer, alu, shared divider and word memory
// path from the accepting edge: jmp and halt go from decode to the result, call, push# and read
// write one word, other stack ops read word memory first, rnd, div and mod use the shared divider
// one instruction at a time; the next transaction is taken while a result waits
// reset: sp, pc and stop flag clear, then a clearing pass over all MEM_WORDS words zeroes
// word memory and written marks before the first instruction is taken
module stack_machine_execute_core #(
  parameter int unsigned MEM_WORDS = smx_pkg::MEM_WORDS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  smx_pkg::smx_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output smx_pkg::smx_out_t out_data
);

  localparam int unsigned AW = $clog2(MEM_WORDS);
  localparam int unsigned SW = $clog2(MEM_WORDS + 1);

  smx_pkg::smx_state_t state, state_next;

  logic [AW-1:0] clr_cnt;
  logic [6:0]    func_r;
  logic [31:0]   arg_r;
  logic [31:0]   rdv_r;
  logic [30:0]   rnd_r;
  logic [SW-1:0] sp;
  logic [15:0]   pc;
  logic          stopped;
  logic [SW-1:0] sp_n;
  logic [15:0]   npc_r;
  logic [2:0]    err_r;
  logic          halt_r;
  logic          wv_r;
  logic [31:0]   wval_r;
  logic [31:0]   t0;
  logic [31:0]   t1;
  logic          mk;
  logic [AW-1:0] raddr_r;
  logic [AW-1:0] waddr_r;
  logic [31:0]   wdata_r;
  logic          wmark_r;

  logic          wrd_we;
  logic [AW-1:0] wrd_waddr;
  logic [31:0]   wrd_wdata;
  logic [31:0]   wrd_rdata;
  logic          mrk_we;
  logic          mrk_wdata;
  logic          mrk_rdata;

  smx_pkg::smx_div_req_t div_req;
  smx_pkg::smx_div_rsp_t div_rsp;

  logic [SW-1:0] sp_m1;
  logic [SW-1:0] sp_m2;
  logic          full;
  logic          sp_zero;
  logic          sp_le1;
  logic [15:0]   pc1;
  logic [15:0]   pc_jump;
  logic          arg_ok;
  logic          t0_ok;
  logic [3:0]    sub;
  logic          sub_big;
  logic          unary;
  logic          is_div;
  logic [2:0]    dec_err;
  logic [31:0]   alu_res;
  logic [31:0]   div_val;
  logic          fin_go;

  // stack and address helpers
  assign sp_m1   = sp - SW'(1);
  assign sp_m2   = sp - SW'(2);
  assign full    = (sp == SW'(MEM_WORDS));
  assign sp_zero = (sp == '0);
  assign sp_le1  = (sp <= SW'(1));
  assign pc1     = pc + 16'd1;
  assign pc_jump = pc1 + arg_r[15:0];
  assign arg_ok  = (arg_r < 32'(MEM_WORDS));
  assign t0_ok   = (t0 < 32'(MEM_WORDS));
  assign sub     = arg_r[3:0];
  assign sub_big = (arg_r > 32'd15);
  assign unary   = (sub == smx_pkg::ALU_NOT) || (sub == smx_pkg::ALU_NEG);
  assign is_div  = (sub == smx_pkg::ALU_DIV) || (sub == smx_pkg::ALU_MOD);
  assign fin_go  = !out_valid || out_ready;

  // faults that follow from sp and the argument alone
  always_comb begin
    dec_err = smx_pkg::ERR_OK;
    case (func_r)
      smx_pkg::OP_PUSH: begin
        if (!arg_ok) dec_err = smx_pkg::ERR_ADDR;
      end
      smx_pkg::OP_IPUSH, smx_pkg::OP_JPZ, smx_pkg::OP_RET: begin
        if (sp_zero) dec_err = smx_pkg::ERR_UNDER;
      end
      smx_pkg::OP_PUSHI, smx_pkg::OP_CALL: begin
        if (full) dec_err = smx_pkg::ERR_OVER;
      end
      smx_pkg::OP_POP: begin
        if (sp_zero) dec_err = smx_pkg::ERR_UNDER;
        else if (!arg_ok) dec_err = smx_pkg::ERR_ADDR;
      end
      smx_pkg::OP_IPOP: begin
        if (sp_le1) dec_err = smx_pkg::ERR_UNDER;
      end
      smx_pkg::OP_DUP: begin
        if (sp_zero) dec_err = smx_pkg::ERR_UNDER;
        else if (full) dec_err = smx_pkg::ERR_OVER;
      end
      smx_pkg::OP_ALU: begin
        if (sp_zero) dec_err = smx_pkg::ERR_UNDER;
        else if (sub_big) dec_err = smx_pkg::ERR_OPCODE;
        else if (!unary && sp_le1) dec_err = smx_pkg::ERR_UNDER;
      end
      smx_pkg::OP_RND: begin
        if (arg_r == '0) dec_err = smx_pkg::ERR_DIVZERO;
        else if (full) dec_err = smx_pkg::ERR_OVER;
      end
      smx_pkg::OP_WRITE, smx_pkg::OP_READ: begin
        if (!arg_ok) dec_err = smx_pkg::ERR_ADDR;
      end
      smx_pkg::OP_JMP, smx_pkg::OP_HALT: dec_err = smx_pkg::ERR_OK;
      default: dec_err = smx_pkg::ERR_OPCODE;
    endcase
  end

  // alu: t1 is the lower word, t0 the top word
  always_comb begin
    case (sub)
      smx_pkg::ALU_AND: alu_res = t1 & t0;
      smx_pkg::ALU_OR:  alu_res = t1 | t0;
      smx_pkg::ALU_XOR: alu_res = t1 ^ t0;
      smx_pkg::ALU_NOT: alu_res = ~t0;
      smx_pkg::ALU_NEG: alu_res = 32'd0 - t0;
      smx_pkg::ALU_ADD: alu_res = t1 + t0;
      smx_pkg::ALU_SUB: alu_res = t1 - t0;
      smx_pkg::ALU_MUL: alu_res = t1 * t0;
      smx_pkg::ALU_EQ:  alu_res = (t1 == t0) ? 32'd0 : 32'd1;
      smx_pkg::ALU_NE:  alu_res = (t1 != t0) ? 32'd0 : 32'd1;
      smx_pkg::ALU_GT:  alu_res = ($signed(t1) >  $signed(t0)) ? 32'd0 : 32'd1;
      smx_pkg::ALU_GE:  alu_res = ($signed(t1) >= $signed(t0)) ? 32'd0 : 32'd1;
      smx_pkg::ALU_LT:  alu_res = ($signed(t1) <  $signed(t0)) ? 32'd0 : 32'd1;
      default:          alu_res = ($signed(t1) <= $signed(t0)) ? 32'd0 : 32'd1;
    endcase
  end

  // divider operands as magnitudes, signs restored on the div and mod results
  always_comb begin
    div_req.start = (state == smx_pkg::ST_DIVGO);
    if (func_r == smx_pkg::OP_RND) begin
      div_req.dividend = {1'b0, rnd_r};
      div_req.divisor  = arg_r[31] ? (32'd0 - arg_r) : arg_r;
    end else begin
      div_req.dividend = t1[31] ? (32'd0 - t1) : t1;
      div_req.divisor  = t0[31] ? (32'd0 - t0) : t0;
    end
    if (func_r == smx_pkg::OP_RND) begin
      div_val = div_rsp.remainder;
    end else if (sub == smx_pkg::ALU_DIV) begin
      div_val = (t1[31] ^ t0[31]) ? (32'd0 - div_rsp.quotient) : div_rsp.quotient;
    end else begin
      div_val = t1[31] ? (32'd0 - div_rsp.remainder) : div_rsp.remainder;
    end
  end

  smx_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      smx_pkg::ST_CLEAR: begin
        if (clr_cnt == AW'(MEM_WORDS - 1)) state_next = smx_pkg::ST_IDLE;
      end
      smx_pkg::ST_IDLE: begin
        if (in_valid) state_next = smx_pkg::ST_DEC;
      end
      smx_pkg::ST_DEC: begin
        if (stopped || dec_err != smx_pkg::ERR_OK) begin
          state_next = smx_pkg::ST_FIN;
        end else if (func_r inside {smx_pkg::OP_PUSHI, smx_pkg::OP_CALL, smx_pkg::OP_READ}) begin
          state_next = smx_pkg::ST_WR;
        end else if (func_r == smx_pkg::OP_RND) begin
          state_next = smx_pkg::ST_DIVGO;
        end else if (func_r inside {smx_pkg::OP_JMP, smx_pkg::OP_HALT}) begin
          state_next = smx_pkg::ST_FIN;
        end else begin
          state_next = smx_pkg::ST_RA;
        end
      end
      smx_pkg::ST_RA: state_next = smx_pkg::ST_CA;
      smx_pkg::ST_CA: state_next = smx_pkg::ST_CHK;
      smx_pkg::ST_CHK: begin
        case (func_r)
          smx_pkg::OP_PUSH: begin
            state_next = (!mk || full) ? smx_pkg::ST_FIN : smx_pkg::ST_WR;
          end
          smx_pkg::OP_IPUSH, smx_pkg::OP_IPOP: begin
            state_next = t0_ok ? smx_pkg::ST_RB : smx_pkg::ST_FIN;
          end
          smx_pkg::OP_POP, smx_pkg::OP_DUP: state_next = smx_pkg::ST_WR;
          smx_pkg::OP_ALU: state_next = unary ? smx_pkg::ST_WR : smx_pkg::ST_RB;
          default: state_next = smx_pkg::ST_FIN;
        endcase
      end
      smx_pkg::ST_RB: state_next = smx_pkg::ST_CB;
      smx_pkg::ST_CB: state_next = smx_pkg::ST_EXEC;
      smx_pkg::ST_EXEC: begin
        if (func_r == smx_pkg::OP_ALU && is_div) begin
          state_next = (t0 == '0) ? smx_pkg::ST_FIN : smx_pkg::ST_DIVGO;
        end else begin
          state_next = smx_pkg::ST_WR;
        end
      end
      smx_pkg::ST_DIVGO: state_next = smx_pkg::ST_DIV;
      smx_pkg::ST_DIV: begin
        if (div_rsp.done) state_next = smx_pkg::ST_WR;
      end
      smx_pkg::ST_WR: state_next = smx_pkg::ST_FIN;
      smx_pkg::ST_FIN: begin
        if (fin_go) state_next = smx_pkg::ST_IDLE;
      end
      default: state_next = smx_pkg::ST_CLEAR;
    endcase
  end

  // memory control and handshake
  always_comb begin
    in_ready  = (state == smx_pkg::ST_IDLE);
    wrd_we    = (state == smx_pkg::ST_CLEAR) || (state == smx_pkg::ST_WR);
    wrd_waddr = (state == smx_pkg::ST_CLEAR) ? clr_cnt : waddr_r;
    wrd_wdata = (state == smx_pkg::ST_CLEAR) ? 32'd0 : wdata_r;
    mrk_we    = (state == smx_pkg::ST_CLEAR) || ((state == smx_pkg::ST_WR) && wmark_r);
    mrk_wdata = (state != smx_pkg::ST_CLEAR);
  end

  smx_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_word_ram (
    .clk   (clk),
    .we    (wrd_we),
    .waddr (wrd_waddr),
    .wdata (wrd_wdata),
    .raddr (raddr_r),
    .rdata (wrd_rdata)
  );

  smx_ram #(.WIDTH(1), .DEPTH(MEM_WORDS)) u_mark_ram (
    .clk   (clk),
    .we    (mrk_we),
    .waddr (wrd_waddr),
    .wdata (mrk_wdata),
    .raddr (raddr_r),
    .rdata (mrk_rdata)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= smx_pkg::ST_CLEAR;
      clr_cnt   <= '0;
      sp        <= '0;
      pc        <= '0;
      stopped   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == smx_pkg::ST_CLEAR) clr_cnt <= clr_cnt + AW'(1);
      if (out_ready) out_valid <= 1'b0;
      // commit and present the result
      if (state == smx_pkg::ST_FIN && fin_go) begin
        out_valid <= 1'b1;
        if (err_r != smx_pkg::ERR_OK) begin
          stopped <= 1'b1;
        end else begin
          sp <= sp_n;
          pc <= npc_r;
          if (halt_r) stopped <= 1'b1;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      smx_pkg::ST_IDLE: begin
        if (in_valid) begin
          func_r <= in_data.func;
          arg_r  <= in_data.argument;
          rdv_r  <= in_data.read_value;
          rnd_r  <= in_data.random_value;
        end
      end
      smx_pkg::ST_DEC: begin
        err_r   <= dec_err;
        halt_r  <= (func_r == smx_pkg::OP_HALT);
        wv_r    <= 1'b0;
        wval_r  <= '0;
        npc_r   <= pc1;
        sp_n    <= sp;
        wmark_r <= 1'b0;
        waddr_r <= sp[AW-1:0];
        raddr_r <= (func_r inside {smx_pkg::OP_PUSH, smx_pkg::OP_WRITE}) ?
                   arg_r[AW-1:0] : sp_m1[AW-1:0];
        case (func_r)
          smx_pkg::OP_PUSH, smx_pkg::OP_DUP, smx_pkg::OP_RND: sp_n <= sp + SW'(1);
          smx_pkg::OP_PUSHI: begin
            sp_n    <= sp + SW'(1);
            wdata_r <= arg_r;
          end
          smx_pkg::OP_CALL: begin
            sp_n    <= sp + SW'(1);
            npc_r   <= pc_jump;
            wdata_r <= {16'd0, pc1};
          end
          smx_pkg::OP_JMP: npc_r <= pc_jump;
          smx_pkg::OP_POP, smx_pkg::OP_JPZ, smx_pkg::OP_RET: sp_n <= sp_m1;
          smx_pkg::OP_IPOP: sp_n <= sp_m2;
          smx_pkg::OP_ALU: sp_n <= unary ? sp : sp_m1;
          smx_pkg::OP_READ: begin
            waddr_r <= arg_r[AW-1:0];
            wdata_r <= rdv_r;
            wmark_r <= 1'b1;
          end
          default: sp_n <= sp;
        endcase
        // a stopped machine only reports its pc
        if (stopped) begin
          err_r  <= smx_pkg::ERR_OK;
          halt_r <= 1'b1;
          npc_r  <= pc;
          sp_n   <= sp;
        end
      end
      smx_pkg::ST_CA: begin
        t0 <= wrd_rdata;
        mk <= mrk_rdata;
      end
      smx_pkg::ST_CHK: begin
        case (func_r)
          smx_pkg::OP_PUSH: begin
            if (!mk) err_r <= smx_pkg::ERR_UNWRITTEN;
            else if (full) err_r <= smx_pkg::ERR_OVER;
            wdata_r <= t0;
          end
          smx_pkg::OP_IPUSH: begin
            if (!t0_ok) err_r <= smx_pkg::ERR_ADDR;
            raddr_r <= t0[AW-1:0];
          end
          smx_pkg::OP_IPOP: begin
            if (!t0_ok) err_r <= smx_pkg::ERR_ADDR;
            raddr_r <= sp_m2[AW-1:0];
          end
          smx_pkg::OP_POP: begin
            waddr_r <= arg_r[AW-1:0];
            wdata_r <= t0;
            wmark_r <= 1'b1;
          end
          smx_pkg::OP_DUP: wdata_r <= t0;
          smx_pkg::OP_ALU: begin
            waddr_r <= sp_m1[AW-1:0];
            wdata_r <= alu_res;
            raddr_r <= sp_m2[AW-1:0];
          end
          smx_pkg::OP_JPZ: begin
            if (t0 == '0) npc_r <= pc_jump;
          end
          smx_pkg::OP_RET: npc_r <= t0[15:0];
          smx_pkg::OP_WRITE: begin
            wv_r   <= 1'b1;
            wval_r <= t0;
          end
          default: wv_r <= 1'b0;
        endcase
      end
      smx_pkg::ST_CB: t1 <= wrd_rdata;
      smx_pkg::ST_EXEC: begin
        case (func_r)
          smx_pkg::OP_IPUSH: begin
            waddr_r <= sp_m1[AW-1:0];
            wdata_r <= t1;
          end
          smx_pkg::OP_IPOP: begin
            waddr_r <= t0[AW-1:0];
            wdata_r <= t1;
            wmark_r <= 1'b1;
          end
          default: begin
            if (is_div && t0 == '0) err_r <= smx_pkg::ERR_DIVZERO;
            waddr_r <= sp_m2[AW-1:0];
            wdata_r <= alu_res;
          end
        endcase
      end
      smx_pkg::ST_DIV: begin
        if (div_rsp.done) wdata_r <= div_val;
      end
      smx_pkg::ST_FIN: begin
        if (fin_go) begin
          if (err_r != smx_pkg::ERR_OK) begin
            out_data.next_pc     <= pc;
            out_data.write_valid <= 1'b0;
            out_data.write_value <= '0;
            out_data.halted      <= 1'b1;
            out_data.error_code  <= err_r;
          end else begin
            out_data.next_pc     <= npc_r;
            out_data.write_valid <= wv_r;
            out_data.write_value <= wval_r;
            out_data.halted      <= halt_r;
            out_data.error_code  <= smx_pkg::ERR_OK;
          end
        end
      end
      default: mk <= mk;
    endcase
  end

endmodule

@@ rtl/smx_chk.sv @@
// port checker for the stack machine execute core, bound to the top level
`include "stack_machine_execute_core_defines.svh"

module smx_chk (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input smx_pkg::smx_in_t  in_data,
  input logic              out_valid,
  input logic              out_ready,
  input smx_pkg::smx_out_t out_data
);

  // a stalled result transaction holds
  `SMX_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")

  // one instruction at a time
  `SMX_ASSERT_NXT(a_busy, in_valid && in_ready, !in_ready, "input taken while busy")

  // a fault always stops the machine
  `SMX_ASSERT_IMP(a_err_halt, out_valid && out_data.error_code != smx_pkg::ERR_OK, out_data.halted, "fault without halt")

  // an emitted word comes only from a clean, running step
  `SMX_ASSERT_IMP(a_wv_clean, out_valid && out_data.write_valid, !out_data.halted && out_data.error_code == smx_pkg::ERR_OK, "write with fault or halt")

endmodule

bind stack_machine_execute_core smx_chk u_smx_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
